// File: hw/rtl/svf_pkg.sv
// Shared types, constants and register codes for the state variable filter.
package svf_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF  = 40;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Fraction bits of the coefficient formats, used as right shifts after a product.
  localparam logic [4:0] SH_GC  = 5'd20;
  localparam logic [4:0] SH_S   = 5'd30;
  localparam logic [4:0] SH_MIX = 5'd24;

  localparam logic        BYPASS_RST   = 1'b1;
  localparam logic [31:0] COEF_G_RST   = 32'h0000_0000;
  localparam logic [31:0] COEF_C_RST   = 32'h0000_0000;
  localparam logic [30:0] COEF_S_RST   = 31'h4000_0000;
  localparam logic [31:0] MIX_LOW_RST  = 32'h0000_0000;
  localparam logic [31:0] MIX_BAND_RST = 32'h0000_0000;
  localparam logic [31:0] MIX_HIGH_RST = 32'h0100_0000;

  typedef enum logic [2:0] {
    REG_BYPASS   = 3'd0,
    REG_COEF_G   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_S   = 3'd3,
    REG_MIX_LOW  = 3'd4,
    REG_MIX_BAND = 3'd5,
    REG_MIX_HIGH = 3'd6
  } reg_idx_t;

  // The seven products of one filtered sample, in the order they are formed.
  typedef enum logic [2:0] {
    PR_Z1C  = 3'd0,
    PR_TS   = 3'd1,
    PR_YHG  = 3'd2,
    PR_YBG  = 3'd3,
    PR_MIXH = 3'd4,
    PR_MIXB = 3'd5,
    PR_MIXL = 3'd6
  } prod_t;

  typedef struct packed {
    logic        bypass;
    logic [31:0] coef_g;
    logic [31:0] coef_c;
    logic [30:0] coef_s;
    logic [31:0] mix_low;
    logic [31:0] mix_band;
    logic [31:0] mix_high;
  } cfg_t;

  typedef struct packed {
    logic  take_in;
    logic  mul_lo;
    logic  mul_hi;
    logic  fin;
    logic  alu;
    logic  out_load;
    logic  bypass;
    prod_t prod;
  } cmd_t;

endpackage

// File: hw/rtl/svf_cfg.sv
// Configuration register file behind the APB-style port.
module svf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [svf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [svf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output svf_pkg::cfg_t                 regs
);
  import svf_pkg::*;

  cfg_t     regs_r;
  cfg_t     regs_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        REG_BYPASS:   regs_nxt.bypass   = pwdata[0];
        REG_COEF_G:   regs_nxt.coef_g   = pwdata;
        REG_COEF_C:   regs_nxt.coef_c   = pwdata;
        REG_COEF_S:   regs_nxt.coef_s   = pwdata[30:0];
        REG_MIX_LOW:  regs_nxt.mix_low  = pwdata;
        REG_MIX_BAND: regs_nxt.mix_band = pwdata;
        REG_MIX_HIGH: regs_nxt.mix_high = pwdata;
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BYPASS:   prdata = {31'b0, regs_r.bypass};
      REG_COEF_G:   prdata = regs_r.coef_g;
      REG_COEF_C:   prdata = regs_r.coef_c;
      REG_COEF_S:   prdata = {1'b0, regs_r.coef_s};
      REG_MIX_LOW:  prdata = regs_r.mix_low;
      REG_MIX_BAND: prdata = regs_r.mix_band;
      REG_MIX_HIGH: prdata = regs_r.mix_high;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.bypass   <= BYPASS_RST;
      regs_r.coef_g   <= COEF_G_RST;
      regs_r.coef_c   <= COEF_C_RST;
      regs_r.coef_s   <= COEF_S_RST;
      regs_r.mix_low  <= MIX_LOW_RST;
      regs_r.mix_band <= MIX_BAND_RST;
      regs_r.mix_high <= MIX_HIGH_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: hw/rtl/svf_ctrl.sv
// Sequencer: walks each sample through the seven products (skipped in bypass) and the output register.
module svf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bypass,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output svf_pkg::cmd_t cmd
);
  import svf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LO   = 6'b000010,
    S_HI   = 6'b000100,
    S_FIN  = 6'b001000,
    S_ALU  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  prod_t  prod_r, prod_nxt;
  logic   byp_r, byp_nxt;
  logic   oval_r, oval_nxt;
  logic   slot_free;

  assign slot_free  = !oval_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;

  always_comb begin
    cmd          = '0;
    cmd.take_in  = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_lo   = (state_r == S_LO);
    cmd.mul_hi   = (state_r == S_HI);
    cmd.fin      = (state_r == S_FIN);
    cmd.alu      = (state_r == S_ALU);
    cmd.out_load = (state_r == S_OUT) && slot_free;
    cmd.bypass   = byp_r;
    cmd.prod     = prod_r;
  end

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    byp_nxt   = byp_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byp_nxt  = bypass;
          prod_nxt = PR_Z1C;
          state_nxt = bypass ? S_OUT : S_LO;
        end
      end
      S_LO:  state_nxt = S_HI;
      S_HI:  state_nxt = S_FIN;
      S_FIN: state_nxt = S_ALU;
      S_ALU: begin
        if (prod_r == PR_MIXL) begin
          state_nxt = S_OUT;
        end else begin
          prod_nxt  = prod_t'(prod_r + 3'd1);
          state_nxt = S_LO;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output beat stays valid until taken; a new one can load in the same cycle.
  always_comb begin
    oval_nxt = oval_r;
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prod_r  <= PR_Z1C;
      byp_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= prod_nxt;
      byp_r   <= byp_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// File: hw/rtl/svf_dp.sv
// Datapath: shared two-pass multiplier, rounding, saturating adders and filter state.
module svf_dp #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = svf_pkg::STATE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  svf_pkg::cmd_t                 cmd,
  input  svf_pkg::cfg_t                 regs,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_clipped
);
  import svf_pkg::*;

  localparam int SB    = STATE_BITS;
  localparam int SW    = SAMPLE_BITS;
  localparam int GUARD = (SB - SW) / 2;
  localparam int HALF  = (SB + 1) / 2;
  localparam int PW    = SB + 33;

  localparam logic signed [SB-1:0] ST_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] ST_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB+1:0] W_MAX  = {2'b00, ST_MAX};
  localparam logic signed [SB+1:0] W_MIN  = {2'b11, ST_MIN};
  localparam logic [PW-1:0] MAG_NEG = {{(PW-1){1'b0}}, 1'b1} << (SB - 1);
  localparam logic [PW-1:0] MAG_POS = MAG_NEG - 1'b1;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SB+1:0] SMAG_NEG = {{(SB+1){1'b0}}, 1'b1} << (SW - 1);
  localparam logic [SB+1:0] SMAG_POS = SMAG_NEG - 1'b1;
  localparam logic [SB+1:0] RND_OUT  = ({{(SB+1){1'b0}}, 1'b1} << GUARD) >> 1;

  logic signed [SW-1:0]   x_r;
  logic signed [SB-1:0]   z1_r, z2_r, t_r, yh_r, yb_r, yl_r, q_r;
  logic signed [SB+1:0]   acc_r;
  logic [HALF+31:0]       pp_r, lo_r;
  logic signed [SW-1:0]   out_sample_r;
  logic                   out_clip_r;

  // Operand selection and sign-magnitude split.
  logic signed [SB-1:0] op_a;
  logic signed [32:0]   op_b;
  logic [4:0]           sh_amt;
  logic [SB-1:0]        mag_a;
  logic [31:0]          mag_b;
  logic [HALF-1:0]      a_part;
  logic                 neg;
  logic [PW-1:0]        rnd, full, shifted;
  logic signed [SB-1:0] q_nxt;

  always_comb begin
    case (cmd.prod)
      PR_Z1C: begin
        op_a = z1_r; op_b = {1'b0, regs.coef_c}; sh_amt = SH_GC;
      end
      PR_TS: begin
        op_a = t_r; op_b = {2'b00, regs.coef_s}; sh_amt = SH_S;
      end
      PR_YHG: begin
        op_a = yh_r; op_b = {1'b0, regs.coef_g}; sh_amt = SH_GC;
      end
      PR_YBG: begin
        op_a = yb_r; op_b = {1'b0, regs.coef_g}; sh_amt = SH_GC;
      end
      PR_MIXH: begin
        op_a = yh_r; op_b = {regs.mix_high[31], regs.mix_high}; sh_amt = SH_MIX;
      end
      PR_MIXB: begin
        op_a = yb_r; op_b = {regs.mix_band[31], regs.mix_band}; sh_amt = SH_MIX;
      end
      PR_MIXL: begin
        op_a = yl_r; op_b = {regs.mix_low[31], regs.mix_low}; sh_amt = SH_MIX;
      end
      default: begin
        op_a = z1_r; op_b = '0; sh_amt = SH_GC;
      end
    endcase
  end

  assign mag_a  = op_a[SB-1] ? SB'(-op_a) : SB'(op_a);
  assign mag_b  = op_b[32] ? 32'(-op_b) : op_b[31:0];
  assign neg    = op_a[SB-1] ^ op_b[32];
  assign a_part = cmd.mul_hi ? HALF'(mag_a >> HALF) : mag_a[HALF-1:0];

  // Rounding half away from zero works on the magnitude; the sign goes back on last.
  assign rnd     = {{(PW-1){1'b0}}, 1'b1} << (sh_amt - 5'd1);
  assign full    = PW'(lo_r) + (PW'(pp_r) << HALF) + rnd;
  assign shifted = full >> sh_amt;

  always_comb begin
    if (neg) begin
      q_nxt = (shifted > MAG_NEG) ? ST_MIN : -(SB'(shifted));
    end else begin
      q_nxt = (shifted > MAG_POS) ? ST_MAX : SB'(shifted);
    end
  end

  // Saturating adders on the rounded product.
  logic signed [SB+1:0] q_w, xs_w, z1_w, z2_w, yb_w, yl_w;
  logic signed [SB+1:0] sum_w, nz1_w, nz2_w;
  logic signed [SB-1:0] sum_sat, nz1_sat, nz2_sat;

  assign q_w  = (SB+2)'(q_r);
  assign xs_w = $signed((SB+2)'(x_r)) <<< GUARD;
  assign z1_w = (SB+2)'(z1_r);
  assign z2_w = (SB+2)'(z2_r);
  assign yb_w = (SB+2)'(yb_r);
  assign yl_w = (SB+2)'(yl_r);

  always_comb begin
    case (cmd.prod)
      PR_Z1C:  sum_w = xs_w - q_w - z2_w;
      PR_YHG:  sum_w = z1_w + q_w;
      PR_YBG:  sum_w = z2_w + q_w;
      default: sum_w = q_w;
    endcase
  end

  assign nz1_w = (yb_w <<< 1) - z1_w;
  assign nz2_w = (yl_w <<< 1) - z2_w;

  assign sum_sat = (sum_w > W_MAX) ? ST_MAX : (sum_w < W_MIN) ? ST_MIN : SB'(sum_w);
  assign nz1_sat = (nz1_w > W_MAX) ? ST_MAX : (nz1_w < W_MIN) ? ST_MIN : SB'(nz1_w);
  assign nz2_sat = (nz2_w > W_MAX) ? ST_MAX : (nz2_w < W_MIN) ? ST_MIN : SB'(nz2_w);

  // Final scaling of the mix by the guard bits and saturation to the sample width.
  logic [SB+1:0]        amag, omag;
  logic                 ovf;
  logic signed [SW-1:0] res;

  assign amag = acc_r[SB+1] ? (SB+2)'(-acc_r) : (SB+2)'(acc_r);
  assign omag = (amag + RND_OUT) >> GUARD;

  always_comb begin
    if (acc_r[SB+1]) begin
      ovf = omag > SMAG_NEG;
      res = ovf ? SMP_MIN : -(SW'(omag));
    end else begin
      ovf = omag > SMAG_POS;
      res = ovf ? SMP_MAX : SW'(omag);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x_r <= in_sample;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp_r <= {32'b0, a_part} * {{HALF{1'b0}}, mag_b};
    end
    if (cmd.mul_hi) begin
      lo_r <= pp_r;
    end
    if (cmd.fin) begin
      q_r <= q_nxt;
    end
    if (cmd.alu) begin
      case (cmd.prod)
        PR_Z1C:  t_r   <= sum_sat;
        PR_TS:   yh_r  <= q_r;
        PR_YHG:  yb_r  <= sum_sat;
        PR_YBG:  yl_r  <= sum_sat;
        PR_MIXH: acc_r <= q_w;
        PR_MIXB: acc_r <= acc_r + q_w;
        PR_MIXL: acc_r <= acc_r + q_w;
        default: acc_r <= acc_r;
      endcase
    end
    if (cmd.out_load) begin
      out_sample_r <= cmd.bypass ? x_r : res;
      out_clip_r   <= cmd.bypass ? 1'b0 : ovf;
    end
  end

  // Integrator state updates once all three taps have been read for the mix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
      z2_r <= '0;
    end else if (cmd.alu && cmd.prod == PR_MIXL) begin
      z1_r <= nz1_sat;
      z2_r <= nz2_sat;
    end
  end

  assign out_sample  = out_sample_r;
  assign out_clipped = out_clip_r;

endmodule

// File: hw/rtl/state_variable_eq_filter.sv
// Trapezoidal state variable EQ filter for one audio channel, with stream ports and APB setup.
//
// Each input beat carries one signed sample; each output beat carries the filtered
// sample (highpass, bandpass and lowpass outputs mixed by three programmable gains),
// rounded and saturated, with a clip flag in tuser. Seven products pass one at a time
// through a single shared multiplier of half the state width by 32 bits, each taking
// a low pass, a high pass, a rounding step and an add step; then the output register
// loads once free and the next input can be taken. With bypass set a sample goes straight
// to the output register and the filter state is kept. The output register lets the next
// sample be accepted while a result waits to be taken. Software must write coefficients
// over the APB port only while no sample is in flight; the block does not enforce it.
module state_variable_eq_filter #(
  parameter int  SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF,
  parameter int  STATE_BITS  = svf_pkg::STATE_BITS_DEF,
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [DATA_W-1:0]              in_tdata,   // sample_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [DATA_W-1:0]              out_tdata,  // sample_out
  output logic [0:0]                     out_tuser,  // clipped
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [svf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [svf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [svf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import svf_pkg::*;

  cfg_t                    regs;
  cmd_t                    cmd;
  logic signed [SAMPLE_BITS-1:0] smp_out;
  logic                    clip;

  svf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  svf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .bypass     (regs.bypass),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  svf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .regs        (regs),
    .in_sample   ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .out_sample  (smp_out),
    .out_clipped (clip)
  );

  assign out_tdata = DATA_W'($unsigned(smp_out));
  assign out_tuser = clip;

endmodule
